// ===== design/calc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the calculator keypad display block.
// Used by calc_mul, calc_b2d and calculator_keypad_display; depends on nothing.
`default_nettype none

package calc_pkg;

    // Datapath widths.
    localparam int VALUE_W    = 64;   // running value and saved operand
    localparam int LOW_W      = 32;   // part of the value that is displayed
    localparam int BCD_DIGITS = 10;   // decimal digits of a 32-bit magnitude
    localparam int NUM_OUT    = 10;   // display places on the result word

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [3:0]         place_t;

    // Display place codes beyond the decimal digits.
    localparam place_t CODE_BLANK = 4'd10;
    localparam place_t CODE_MINUS = 4'd11;

    // Key codes on the op field.
    localparam logic [2:0] KEY_DIGIT  = 3'd0;
    localparam logic [2:0] KEY_ADD    = 3'd1;
    localparam logic [2:0] KEY_SUB    = 3'd2;
    localparam logic [2:0] KEY_MUL    = 3'd3;
    localparam logic [2:0] KEY_EQUALS = 3'd4;
    localparam logic [2:0] KEY_CLEAR  = 3'd5;

    // Operation waiting for the equals key.
    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_ADD  = 2'd1,
        PEND_SUB  = 2'd2,
        PEND_MUL  = 2'd3
    } pend_t;

    // Decimal shift for digit entry.
    localparam value_t TEN = 64'd10;

endpackage : calc_pkg

`default_nettype wire

// ===== design/calc_mul.sv =====
`timescale 1ns / 1ps
// Serial shift-and-add multiply-accumulate: product = a * b + c modulo 2^64.
// Depends on calc_pkg for the value type.
`default_nettype none

module calc_mul
    import calc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   start,
    input  wire value_t a,
    input  wire value_t b,
    input  wire value_t c,
    output logic        done,
    output value_t      product
);

    logic   busy_reg;
    logic   busy_next;
    value_t acc_reg;
    value_t acc_next;
    value_t a_reg;
    value_t a_next;
    value_t b_reg;
    value_t b_next;
    logic   b_zero;

    // The multiplier shifts out one bit a cycle; the run ends once it is exhausted.
    assign b_zero  = (b_reg == '0);
    assign done    = busy_reg && b_zero;
    assign product = acc_reg;

    // One conditional add of the shifted multiplicand per cycle.
    always_comb
    begin
        busy_next = busy_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        if (start)
        begin
            busy_next = 1'b1;
            acc_next  = c;
            a_next    = a;
            b_next    = b;
        end
        else if (busy_reg)
        begin
            if (b_zero)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                if (b_reg[0])
                begin
                    acc_next = acc_reg + a_reg;
                end
                a_next = {a_reg[VALUE_W-2:0], 1'b0};
                b_next = {1'b0, b_reg[VALUE_W-1:1]};
            end
        end
    end

    // Control flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

endmodule : calc_mul

`default_nettype wire

// ===== design/calc_b2d.sv =====
`timescale 1ns / 1ps
// Binary to decimal display conversion: shift-and-add-3 over the 32-bit magnitude,
// then leading blanks and minus sign placement. Depends on calc_pkg.
`default_nettype none

module calc_b2d
    import calc_pkg::*;
#(
    parameter int PLACES = 10
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [LOW_W-1:0] value,
    output logic                  done,
    output place_t [PLACES-1:0]   places
);

    localparam int CNT_W = $clog2(LOW_W);

    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [LOW_W-1:0] bin_reg;
    logic [LOW_W-1:0] bin_next;
    logic             neg_reg;
    logic             neg_next;
    place_t           bcd_reg  [BCD_DIGITS];
    place_t           bcd_next [BCD_DIGITS];
    place_t           adj      [BCD_DIGITS];
    place_t           dig      [PLACES];
    logic [PLACES:0]  zero_from;
    logic [PLACES-1:0] blank;

    assign done = done_reg;

    // Each digit at five or more gets three added before the shift.
    always_comb
    begin
        for (int d = 0; d < BCD_DIGITS; d++)
        begin
            adj[d] = (bcd_reg[d] >= 4'd5) ? (bcd_reg[d] + 4'd3) : bcd_reg[d];
        end
    end

    // One magnitude bit enters the decimal register per cycle, MSB first.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        neg_next  = neg_reg;
        bcd_next  = bcd_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = value[LOW_W-1];
            bin_next  = value[LOW_W-1] ? (~value + 1'b1) : value;
            for (int d = 0; d < BCD_DIGITS; d++)
            begin
                bcd_next[d] = '0;
            end
        end
        else if (busy_reg)
        begin
            bcd_next[0] = {adj[0][2:0], bin_reg[LOW_W-1]};
            for (int d = 1; d < BCD_DIGITS; d++)
            begin
                bcd_next[d] = {adj[d][2:0], adj[d-1][3]};
            end
            bin_next = {bin_reg[LOW_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(LOW_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Place k counts from the right; digits above the ten converted ones are zero.
    always_comb
    begin
        for (int k = 0; k < PLACES; k++)
        begin
            if (k < BCD_DIGITS)
            begin
                dig[k] = bcd_reg[k];
            end
            else
            begin
                dig[k] = '0;
            end
        end
        // Digits that do not fit on a short display still keep the places below them lit.
        zero_from[PLACES] = 1'b1;
        for (int k = PLACES; k < BCD_DIGITS; k++)
        begin
            zero_from[PLACES] = zero_from[PLACES] && (bcd_reg[k] == '0);
        end
        for (int k = PLACES - 1; k >= 0; k--)
        begin
            zero_from[k] = zero_from[k+1] && (dig[k] == '0);
        end
        // A place is blank once nothing is left above it; the ones place never is.
        blank[0] = 1'b0;
        for (int k = 1; k < PLACES; k++)
        begin
            blank[k] = zero_from[k];
        end
        // The minus sign takes the first blank place left of the number.
        for (int j = 0; j < PLACES; j++)
        begin
            if (j == PLACES - 1)
            begin
                places[j] = dig[0];
            end
            else if (blank[PLACES-1-j] && neg_reg && !blank[PLACES-2-j])
            begin
                places[j] = CODE_MINUS;
            end
            else if (blank[PLACES-1-j])
            begin
                places[j] = CODE_BLANK;
            end
            else
            begin
                places[j] = dig[PLACES-1-j];
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Conversion datapath.
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        neg_reg <= neg_next;
        bcd_reg <= bcd_next;
    end

endmodule : calc_b2d

`default_nettype wire

// ===== design/calculator_keypad_display.sv =====
`timescale 1ns / 1ps
// Add, subtract and multiply integer calculator controller with a decimal display.
// Depends on calc_pkg, calc_mul and calc_b2d.
//
//  channel | handshake            | word
//  --------+----------------------+----------------------------------
//  key in  | in_valid / in_stall  | op, key_digit
//  display | out_valid / out_stall| place_0 .. place_9
//
// A key that refreshes the display keeps the controller busy: add, subtract and
// clear wait on the decimal conversion, and a digit and a multiply also wait on the serial
// multiplier (one multiplier bit a cycle) before the 32-step decimal conversion.
// Keys that do not refresh leave the controller idle. One key is in work at a time.
// Reset clears the values and the pending operation and blanks the display.
// A finished display word waits in the output register while the next key is taken;
// a refresh behind it holds until that word is taken.
`default_nettype none

module calculator_keypad_display
    import calc_pkg::*;
#(
    parameter int DISPLAY_PLACES = 10
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [2:0] op,
    input  wire logic [3:0] key_digit,
    output logic            out_valid,
    input  wire logic       out_stall,
    output place_t          place_0,
    output place_t          place_1,
    output place_t          place_2,
    output place_t          place_3,
    output place_t          place_4,
    output place_t          place_5,
    output place_t          place_6,
    output place_t          place_7,
    output place_t          place_8,
    output place_t          place_9
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CONV_GO,
        ST_CONV,
        ST_EMIT
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    value_t                      rv_reg;
    value_t                      rv_next;
    value_t                      saved_reg;
    value_t                      saved_next;
    pend_t                       pend_reg;
    pend_t                       pend_next;
    place_t [DISPLAY_PLACES-1:0] display_reg;
    place_t [DISPLAY_PLACES-1:0] display_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    place_t [NUM_OUT-1:0]        out_place_reg;
    place_t [NUM_OUT-1:0]        out_place_next;
    place_t [NUM_OUT-1:0]        out_fill;

    logic                        in_accept;
    logic                        digit_open;
    logic                        mul_start;
    value_t                      mul_b;
    value_t                      mul_c;
    logic                        mul_done;
    value_t                      mul_product;
    logic                        conv_start;
    logic                        conv_done;
    place_t [DISPLAY_PLACES-1:0] conv_places;

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && (state_reg == ST_IDLE);
    assign digit_open = (display_reg[1] == CODE_BLANK);
    assign conv_start = (state_reg == ST_CONV_GO);

    // Shared serial multiplier: digit entry and the multiply operation.
    calc_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (rv_reg),
        .b       (mul_b),
        .c       (mul_c),
        .done    (mul_done),
        .product (mul_product)
    );

    // Display conversion of the low half of the running value.
    calc_b2d #(
        .PLACES (DISPLAY_PLACES)
    ) u_b2d (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (conv_start),
        .value  (rv_reg[LOW_W-1:0]),
        .done   (conv_done),
        .places (conv_places)
    );

    // Places past the display width show blank on the result word.
    for (genvar j = 0; j < NUM_OUT; j++)
    begin : g_fill
        if (j < DISPLAY_PLACES)
        begin : g_place
            assign out_fill[j] = display_reg[j];
        end
        else
        begin : g_pad
            assign out_fill[j] = CODE_BLANK;
        end
    end

    // Key decoding and sequencing.
    always_comb
    begin
        state_next     = state_reg;
        rv_next        = rv_reg;
        saved_next     = saved_reg;
        pend_next      = pend_reg;
        display_next   = display_reg;
        out_place_next = out_place_reg;
        out_valid_next = out_valid_reg && out_stall;
        mul_start      = 1'b0;
        mul_b          = saved_reg;
        mul_c          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (op)
                        KEY_DIGIT:
                        begin
                            if (digit_open)
                            begin
                                mul_start  = 1'b1;
                                mul_b      = TEN;
                                mul_c      = value_t'(key_digit);
                                state_next = ST_MUL;
                            end
                        end
                        KEY_ADD, KEY_SUB, KEY_MUL:
                        begin
                            saved_next = rv_reg;
                            rv_next    = '0;
                            pend_next  = pend_t'(op[1:0]);
                        end
                        KEY_EQUALS:
                        begin
                            case (pend_reg)
                                PEND_ADD:
                                begin
                                    rv_next    = rv_reg + saved_reg;
                                    state_next = ST_CONV_GO;
                                end
                                PEND_SUB:
                                begin
                                    rv_next    = saved_reg - rv_reg;
                                    state_next = ST_CONV_GO;
                                end
                                PEND_MUL:
                                begin
                                    mul_start  = 1'b1;
                                    state_next = ST_MUL;
                                end
                                default:
                                begin
                                    state_next = ST_IDLE;
                                end
                            endcase
                        end
                        KEY_CLEAR:
                        begin
                            rv_next    = '0;
                            pend_next  = PEND_NONE;
                            state_next = ST_CONV_GO;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    rv_next    = mul_product;
                    state_next = ST_CONV_GO;
                end
            end
            ST_CONV_GO:
            begin
                state_next = ST_CONV;
            end
            ST_CONV:
            begin
                if (conv_done)
                begin
                    display_next = conv_places;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // Load the output register once the previous word has gone.
                if (!out_valid_reg || !out_stall)
                begin
                    out_place_next = out_fill;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rv_reg        <= '0;
            saved_reg     <= '0;
            pend_reg      <= PEND_NONE;
            out_valid_reg <= 1'b0;
            out_place_reg <= '0;
            for (int i = 0; i < DISPLAY_PLACES; i++)
            begin
                display_reg[i] <= CODE_BLANK;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rv_reg        <= rv_next;
            saved_reg     <= saved_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            out_place_reg <= out_place_next;
            display_reg   <= display_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign place_0   = out_place_reg[0];
    assign place_1   = out_place_reg[1];
    assign place_2   = out_place_reg[2];
    assign place_3   = out_place_reg[3];
    assign place_4   = out_place_reg[4];
    assign place_5   = out_place_reg[5];
    assign place_6   = out_place_reg[6];
    assign place_7   = out_place_reg[7];
    assign place_8   = out_place_reg[8];
    assign place_9   = out_place_reg[9];

    // A new display word appears only out of the emit step.
    a_word_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("display word raised outside the emit step");

    // The multiplier finishes only while the sequencer waits for it.
    a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_MUL))
        else $error("multiplier finished outside the multiply step");

    // The conversion finishes only while the sequencer waits for it.
    a_conv_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        conv_done |-> (state_reg == ST_CONV))
        else $error("conversion finished outside the conversion step");

    // A digit on a full display is dropped without any work.
    a_digit_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (op == KEY_DIGIT) && !digit_open) |=> (state_reg == ST_IDLE))
        else $error("digit on a full display started work");

endmodule : calculator_keypad_display

`default_nettype wire
